// File: rtl/core/ded_pkg.sv
`default_nettype none

package ded_pkg;

  localparam int unsigned WindowTapsDefault = 8;

  localparam logic [14:0] JerkThrReset    = 15'd600;
  localparam logic [14:0] YawThrReset     = 15'd15000;
  localparam logic [15:0] MinPersistReset = 16'd50;
  localparam logic [15:0] CoolPeriodReset = 16'd1000;

  typedef enum logic [1:0] {
    MODE_IDLE      = 2'd0,
    MODE_DETECTING = 2'd1,
    MODE_EVENT     = 2'd2,
    MODE_COOLDOWN  = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    EV_NONE  = 2'd0,
    EV_ACCEL = 2'd1,
    EV_BRAKE = 2'd2,
    EV_TURN  = 2'd3
  } event_e;

  typedef enum logic [2:0] {
    CFG_JERK_THR    = 3'd0,
    CFG_YAW_THR     = 3'd1,
    CFG_MIN_PERSIST = 3'd2,
    CFG_COOL_PERIOD = 3'd3
  } cfg_idx_e;

endpackage

`default_nettype wire

// File: rtl/core/driving_event_detector.sv
`default_nettype none

// Channel   Direction  Handshake                  Payload
// in        sink       in_valid_i / in_stall_o    accel_long_i, yaw_rate_i, elapsed_ms_i
// out       source     out_valid_o / out_stall_i  event_code_o
// cfg       sink       cfg_valid_i / cfg_ready_o  cfg_index_i, cfg_data_i
//
// One request is taken per cycle while in_stall_o is low; its result is held in the output register until taken.
// The rate is set by the window memory, which is read and written once in the accept cycle.
// Each of the four pipeline stages and the output register holds one request and stalls alone.
// Reset is asynchronous and active low; the window memory starts empty through per-entry
// valid bits, so no clearing pass is needed.

module driving_event_detector import ded_pkg::*; #(
  parameter int unsigned WINDOW_TAPS = WindowTapsDefault
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output      logic               in_stall_o,
  input  wire logic signed [15:0] accel_long_i,
  input  wire logic signed [15:0] yaw_rate_i,
  input  wire logic        [15:0] elapsed_ms_i,
  output      logic               out_valid_o,
  input  wire logic               out_stall_i,
  output      logic        [1:0]  event_code_o,
  input  wire logic               cfg_valid_i,
  output      logic               cfg_ready_o,
  input  wire logic        [2:0]  cfg_index_i,
  input  wire logic        [15:0] cfg_data_i
);

  localparam int unsigned PosW   = $clog2(WINDOW_TAPS);
  localparam int unsigned TotW   = 16 + PosW;
  localparam int unsigned ShiftW = TotW + PosW;
  localparam int unsigned RecipW = TotW + 1;
  localparam int unsigned ProdW  = TotW + RecipW;
  localparam longint unsigned RecipVal =
    ((64'd1 << ShiftW) + 64'(WINDOW_TAPS) - 64'd1) / 64'(WINDOW_TAPS);
  localparam logic [RecipW-1:0] Recip   = RecipW'(RecipVal);
  localparam logic [PosW-1:0]   LastPos = PosW'(WINDOW_TAPS - 1);

  logic [14:0] jerk_thr_q;
  logic [14:0] yaw_thr_q;
  logic [15:0] min_persist_q;
  logic [15:0] cool_period_q;

  logic signed [15:0] win_mem [WINDOW_TAPS];
  logic [WINDOW_TAPS-1:0] win_vld_q;
  logic [PosW-1:0] pos_q;

  logic s1_valid_q, s2_valid_q, s3_valid_q, s4_valid_q, out_valid_q;
  logic s1_ready, s2_ready, s3_ready, s4_ready, out_ready;
  logic in_acc, s1_fire, s2_fire, s3_fire, s4_fire;

  logic signed [15:0] s1_rdata_q;
  logic               s1_rvld_q;
  logic signed [15:0] s1_accel_q;
  logic signed [15:0] s1_yaw_q;
  logic        [15:0] s1_dt_q;
  logic signed [15:0] s1_old;

  logic signed [TotW-1:0] total_q;
  logic signed [15:0]     s2_yaw_q;
  logic        [15:0]     s2_dt_q;

  logic                   tot_neg;
  logic [TotW-1:0]        tot_mag;
  logic [ProdW-1:0]       prod;
  logic [15:0]            s3_quot_q;
  logic                   s3_neg_q;
  logic signed [15:0]     s3_yaw_q;
  logic        [15:0]     s3_dt_q;

  logic signed [16:0] filt;
  logic signed [15:0] prior_q;
  logic signed [16:0] jerk;
  logic signed [16:0] jerk_thr_s;
  logic signed [16:0] yaw_thr_s;
  logic signed [16:0] yaw_s;
  event_e             cand;
  event_e             s4_cand_q;
  logic [15:0]        s4_dt_q;

  mode_e       mode_q, mode_d;
  event_e      pending_q, pending_d;
  logic [15:0] persist_q, persist_d;
  logic [15:0] cool_q, cool_d;
  logic [16:0] persist_sum;
  event_e      emit;
  logic [1:0]  event_code_q;

  assign out_ready = !out_valid_q || !out_stall_i;
  assign s4_ready  = !s4_valid_q || out_ready;
  assign s3_ready  = !s3_valid_q || s4_ready;
  assign s2_ready  = !s2_valid_q || s3_ready;
  assign s1_ready  = !s1_valid_q || s2_ready;

  assign in_stall_o = !s1_ready;
  assign in_acc     = in_valid_i && s1_ready;
  assign s1_fire    = s1_valid_q && s2_ready;
  assign s2_fire    = s2_valid_q && s3_ready;
  assign s3_fire    = s3_valid_q && s4_ready;
  assign s4_fire    = s4_valid_q && out_ready;

  assign cfg_ready_o  = 1'b1;
  assign out_valid_o  = out_valid_q;
  assign event_code_o = event_code_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      jerk_thr_q    <= JerkThrReset;
      yaw_thr_q     <= YawThrReset;
      min_persist_q <= MinPersistReset;
      cool_period_q <= CoolPeriodReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_JERK_THR:    jerk_thr_q    <= cfg_data_i[14:0];
        CFG_YAW_THR:     yaw_thr_q     <= cfg_data_i[14:0];
        CFG_MIN_PERSIST: min_persist_q <= cfg_data_i;
        CFG_COOL_PERIOD: cool_period_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // The window entry is read before it is overwritten in the same cycle.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_rdata_q      <= win_mem[pos_q];
      win_mem[pos_q]  <= accel_long_i;
      s1_accel_q      <= accel_long_i;
      s1_yaw_q        <= yaw_rate_i;
      s1_dt_q         <= elapsed_ms_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_vld_q <= '0;
      s1_rvld_q <= 1'b0;
      pos_q     <= '0;
    end else if (in_acc) begin
      s1_rvld_q        <= win_vld_q[pos_q];
      win_vld_q[pos_q] <= 1'b1;
      pos_q            <= (pos_q == LastPos) ? '0 : pos_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      s3_valid_q  <= 1'b0;
      s4_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s1_ready)  s1_valid_q  <= in_valid_i;
      if (s2_ready)  s2_valid_q  <= s1_valid_q;
      if (s3_ready)  s3_valid_q  <= s2_valid_q;
      if (s4_ready)  s4_valid_q  <= s3_valid_q;
      if (out_ready) out_valid_q <= s4_valid_q;
    end
  end

  // Running window sum; it changes exactly when stage two is loaded.
  assign s1_old = s1_rvld_q ? s1_rdata_q : 16'sd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q <= '0;
    end else if (s1_fire) begin
      total_q <= total_q - TotW'(s1_old) + TotW'(s1_accel_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire) begin
      s2_yaw_q <= s1_yaw_q;
      s2_dt_q  <= s1_dt_q;
    end
  end

  // Division of the magnitude by the tap count through an exact reciprocal.
  assign tot_neg = total_q[TotW-1];
  assign tot_mag = tot_neg ? TotW'(-total_q) : TotW'(total_q);
  assign prod    = ProdW'(tot_mag) * ProdW'(Recip);

  always_ff @(posedge clk_i) begin
    if (s2_fire) begin
      s3_quot_q <= prod[ShiftW +: 16];
      s3_neg_q  <= tot_neg;
      s3_yaw_q  <= s2_yaw_q;
      s3_dt_q   <= s2_dt_q;
    end
  end

  assign filt       = s3_neg_q ? -$signed({1'b0, s3_quot_q}) : $signed({1'b0, s3_quot_q});
  assign jerk       = filt - 17'(prior_q);
  assign jerk_thr_s = $signed({2'b00, jerk_thr_q});
  assign yaw_thr_s  = $signed({2'b00, yaw_thr_q});
  assign yaw_s      = 17'(s3_yaw_q);

  always_comb begin
    if (jerk > jerk_thr_s) begin
      cand = EV_ACCEL;
    end else if (jerk < -jerk_thr_s) begin
      cand = EV_BRAKE;
    end else if ((yaw_s > yaw_thr_s) || (yaw_s < -yaw_thr_s)) begin
      cand = EV_TURN;
    end else begin
      cand = EV_NONE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prior_q <= '0;
    end else if (s3_fire) begin
      prior_q <= filt[15:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (s3_fire) begin
      s4_cand_q <= cand;
      s4_dt_q   <= s3_dt_q;
    end
  end

  assign persist_sum = {1'b0, persist_q} + {1'b0, s4_dt_q};

  always_comb begin
    mode_d = mode_q;
    unique case (mode_q)
      MODE_IDLE: begin
        if (s4_cand_q != EV_NONE) mode_d = MODE_DETECTING;
      end
      MODE_DETECTING: begin
        if (s4_cand_q != pending_q) begin
          mode_d = MODE_IDLE;
        end else if (persist_d >= min_persist_q) begin
          mode_d = MODE_EVENT;
        end
      end
      MODE_EVENT: begin
        mode_d = MODE_COOLDOWN;
      end
      MODE_COOLDOWN: begin
        if (s4_dt_q >= cool_q) mode_d = MODE_IDLE;
      end
      default: mode_d = MODE_IDLE;
    endcase
  end

  always_comb begin
    pending_d = pending_q;
    persist_d = persist_q;
    cool_d    = cool_q;
    emit      = EV_NONE;
    unique case (mode_q)
      MODE_IDLE: begin
        if (s4_cand_q != EV_NONE) begin
          pending_d = s4_cand_q;
          persist_d = s4_dt_q;
        end
      end
      MODE_DETECTING: begin
        if (s4_cand_q == pending_q) begin
          persist_d = persist_sum[16] ? 16'hFFFF : persist_sum[15:0];
          if (persist_d >= min_persist_q) begin
            emit   = pending_q;
            cool_d = cool_period_q;
          end
        end else begin
          pending_d = EV_NONE;
          persist_d = '0;
        end
      end
      MODE_EVENT: ;
      MODE_COOLDOWN: begin
        if (s4_dt_q >= cool_q) begin
          cool_d    = '0;
          pending_d = EV_NONE;
          persist_d = '0;
        end else begin
          cool_d = cool_q - s4_dt_q;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= MODE_IDLE;
      pending_q <= EV_NONE;
      persist_q <= '0;
      cool_q    <= '0;
    end else if (s4_fire) begin
      mode_q    <= mode_d;
      pending_q <= pending_d;
      persist_q <= persist_d;
      cool_q    <= cool_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s4_fire) begin
      event_code_q <= emit;
    end
  end

  a_emit_in_event: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (event_code_o != EV_NONE)) |-> (mode_q == MODE_EVENT))
    else $error("An emitted event is not matched by the event mode.");

  a_idle_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mode_q == MODE_IDLE) |-> ((pending_q == EV_NONE) && (persist_q == '0)))
    else $error("Idle mode holds a pending candidate.");

  a_detect_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mode_q == MODE_DETECTING) |-> (pending_q != EV_NONE))
    else $error("Detecting mode has no pending candidate.");

  a_pos_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> (pos_q == (($past(pos_q) == LastPos) ? '0 : $past(pos_q) + 1'b1)))
    else $error("Window position did not advance with an accepted request.");

  a_event_one_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s4_fire && (mode_q == MODE_EVENT)) |=> (mode_q == MODE_COOLDOWN))
    else $error("Event mode lasted more than one request.");

endmodule

`default_nettype wire

// File: test/ded_event_check.sv
`timescale 1ns / 100ps

module ded_event_check import ded_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_stall_i,
  input  logic signed [15:0] accel_long_i,
  input  logic signed [15:0] yaw_rate_i,
  input  logic        [15:0] elapsed_ms_i,
  input  logic               out_valid_i,
  input  logic               out_stall_i,
  input  logic        [1:0]  event_code_i,
  input  logic               cfg_valid_i,
  input  logic               cfg_ready_i,
  input  logic        [2:0]  cfg_index_i,
  input  logic        [15:0] cfg_data_i,
  output int                 err_count_o,
  output int                 pending_o
);

  localparam int Taps = WindowTapsDefault;

  logic        [14:0] jerk_thr;
  logic        [14:0] yaw_thr;
  logic        [15:0] min_persist;
  logic        [15:0] cool_period;

  logic signed [15:0] taps [Taps];
  int                 tap_pos;
  int                 tap_sum;
  int                 last_avg;
  mode_e              det_mode;
  event_e             held_event;
  int                 persist;
  int                 cool_left;

  event_e             event_codes_due [$];
  int                 errors = 0;

  task automatic report_mismatch(string what, int got, int want);
    $display("%0t ns: %s: got %0d, expected %0d", $time, what, got, want);
    errors++;
  endtask

  function automatic event_e detector_step(logic signed [15:0] ax, logic signed [15:0] gz,
                                           logic [15:0] dt);
    int     avg;
    int     jerk;
    int     yaw;
    int     jt;
    int     yt;
    int     el;
    event_e cand;
    event_e emit;
    tap_sum       = tap_sum - taps[tap_pos] + ax;
    taps[tap_pos] = ax;
    tap_pos       = (tap_pos + 1) % Taps;
    avg           = tap_sum / Taps;
    jerk          = avg - last_avg;
    last_avg      = avg;
    jt            = jerk_thr;
    yt            = yaw_thr;
    yaw           = gz;
    el            = dt;
    emit          = EV_NONE;

    if (jerk > jt) begin
      cand = EV_ACCEL;
    end else if (jerk < -jt) begin
      cand = EV_BRAKE;
    end else if (yaw > yt || yaw < -yt) begin
      cand = EV_TURN;
    end else begin
      cand = EV_NONE;
    end

    case (det_mode)
      MODE_IDLE: begin
        if (cand != EV_NONE) begin
          det_mode   = MODE_DETECTING;
          held_event = cand;
          persist    = el;
        end
      end
      MODE_DETECTING: begin
        if (cand == held_event) begin
          persist = persist + el;
          if (persist > 65535) persist = 65535;
          if (persist >= int'(min_persist)) begin
            det_mode  = MODE_EVENT;
            emit      = held_event;
            cool_left = cool_period;
          end
        end else begin
          det_mode   = MODE_IDLE;
          persist    = 0;
          held_event = EV_NONE;
        end
      end
      MODE_EVENT: begin
        det_mode = MODE_COOLDOWN;
      end
      default: begin
        if (el >= cool_left) begin
          cool_left  = 0;
          det_mode   = MODE_IDLE;
          held_event = EV_NONE;
          persist    = 0;
        end else begin
          cool_left = cool_left - el;
        end
      end
    endcase
    return emit;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    event_e want;
    if (!rst_ni) begin
      jerk_thr    = JerkThrReset;
      yaw_thr     = YawThrReset;
      min_persist = MinPersistReset;
      cool_period = CoolPeriodReset;
      foreach (taps[i]) taps[i] = '0;
      tap_pos     = 0;
      tap_sum     = 0;
      last_avg    = 0;
      det_mode    = MODE_IDLE;
      held_event  = EV_NONE;
      persist     = 0;
      cool_left   = 0;
      event_codes_due.delete();
      pending_o   <= 0;
      err_count_o <= errors;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_idx_e'(cfg_index_i))
          CFG_JERK_THR:    jerk_thr    = cfg_data_i[14:0];
          CFG_YAW_THR:     yaw_thr     = cfg_data_i[14:0];
          CFG_MIN_PERSIST: min_persist = cfg_data_i;
          CFG_COOL_PERIOD: cool_period = cfg_data_i;
          default: ;
        endcase
      end
      if (out_valid_i && !out_stall_i) begin
        if (event_codes_due.size() == 0) begin
          report_mismatch("event_code with no request pending", event_code_i, EV_NONE);
        end else begin
          want = event_codes_due.pop_front();
          if (event_code_i !== want) report_mismatch("event_code", event_code_i, want);
        end
      end
      if (in_valid_i && !in_stall_i) begin
        event_codes_due.push_back(detector_step(accel_long_i, yaw_rate_i, elapsed_ms_i));
      end
      pending_o   <= event_codes_due.size();
      err_count_o <= errors;
    end
  end

endmodule

// File: test/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import ded_pkg::*;

  localparam int WatchdogLimit = 1000;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  logic signed [15:0] accel_long;
  logic signed [15:0] yaw_rate;
  logic        [15:0] elapsed_ms;
  logic               out_valid;
  logic               out_stall;
  logic        [1:0]  event_code;
  logic               cfg_valid;
  logic               cfg_ready;
  logic        [2:0]  cfg_index;
  logic        [15:0] cfg_data;

  int                 err_count;
  int                 pending;
  int                 idle_cycles = 0;
  bit                 no_gaps = 1'b0;
  int                 cur_yaw = YawThrReset;
  int                 cur_min = MinPersistReset;

  driving_event_detector dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall),
    .accel_long_i (accel_long),
    .yaw_rate_i   (yaw_rate),
    .elapsed_ms_i (elapsed_ms),
    .out_valid_o  (out_valid),
    .out_stall_i  (out_stall),
    .event_code_o (event_code),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_o  (cfg_ready),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data)
  );

  ded_event_check event_check (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .accel_long_i (accel_long),
    .yaw_rate_i   (yaw_rate),
    .elapsed_ms_i (elapsed_ms),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .event_code_i (event_code),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_i  (cfg_ready),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data),
    .err_count_o  (err_count),
    .pending_o    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == WatchdogLimit) begin
      $display("FAILURE");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic int pause_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 50);
  endfunction

  function automatic logic [15:0] pick_elapsed();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 16'($urandom_range(0, cur_min / 3 + 20));
    if (r < 80) return 16'($urandom_range(0, 200));
    if (r < 95) return 16'($urandom_range(0, 2000));
    return 16'($urandom);
  endfunction

  // The result side stalls on its own schedule, with occasional long free-running stretches.
  initial begin
    int hold;
    int run;
    out_stall <= 1'b0;
    @(posedge rst_n);
    forever begin
      run = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 200) : $urandom_range(1, 24);
      repeat (run) @(posedge clk);
      hold = pause_len();
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  task automatic send_sample(logic signed [15:0] ax, logic signed [15:0] gz, logic [15:0] dt);
    int gap;
    gap = no_gaps ? 0 : pause_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    accel_long <= ax;
    yaw_rate   <= gz;
    elapsed_ms <= dt;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [15:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_limits(logic [15:0] jerk_w, logic [15:0] yaw_w, logic [15:0] min_w,
                            logic [15:0] cool_w);
    drain_results();
    write_reg(CFG_JERK_THR, jerk_w);
    write_reg(CFG_YAW_THR, yaw_w);
    write_reg(CFG_MIN_PERSIST, min_w);
    write_reg(CFG_COOL_PERIOD, cool_w);
    write_reg(3'(CFG_COOL_PERIOD) + 3'($urandom_range(1, 4)), 16'($urandom));
    cur_yaw = yaw_w[14:0];
    cur_min = min_w;
  endtask

  // Most samples come in bursts that hold one kind of maneuver long enough to persist.
  task automatic run_random(int count);
    int                 kind;
    int                 left;
    int                 mag;
    logic signed [15:0] ax;
    logic signed [15:0] gz;
    left = 0;
    kind = 0;
    ax   = '0;
    for (int n = 0; n < count; n++) begin
      if (left == 0) begin
        kind    = $urandom_range(0, 9);
        left    = $urandom_range(1, 12);
        no_gaps = ($urandom_range(0, 5) == 0);
      end
      left--;
      gz = 16'($urandom);
      case (kind)
        0, 1: ax = 16'sh7fff - 16'($urandom_range(0, 2047));
        2, 3: ax = -16'sh8000 + 16'($urandom_range(0, 2047));
        4: ax = 16'($urandom_range(0, 65535));
        5, 6, 7: begin
          mag = $urandom_range(cur_yaw, 32767);
          gz  = $urandom_range(0, 1) ? ~16'(mag) : 16'(mag);
        end
        default: ax = 16'($urandom);
      endcase
      send_sample(ax, gz, pick_elapsed());
    end
    no_gaps = 1'b0;
  endtask

  initial begin
    rst_n      <= 1'b0;
    in_valid   <= 1'b0;
    accel_long <= '0;
    yaw_rate   <= '0;
    elapsed_ms <= '0;
    cfg_valid  <= 1'b0;
    cfg_index  <= '0;
    cfg_data   <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Hard accel with a saturating persistence sum, then cooldown ended by a long interval.
    send_sample(16'sd0, 16'sd0, 16'd0);
    send_sample(16'sh7fff, 16'sd0, 16'd10);
    send_sample(16'sh7fff, 16'sd0, 16'd65535);
    send_sample(16'sh7fff, 16'sd0, 16'd0);
    send_sample(16'sh7fff, 16'sh7fff, 16'd500);
    send_sample(16'sh7fff, -16'sh8000, 16'd65535);
    // Hard brake reached over several steps, cooldown ending exactly on its period.
    for (int i = 0; i < 5; i++) send_sample(-16'sh8000, 16'sd0, (i < 3) ? 16'd20 : 16'd1000);
    for (int i = 0; i < 6; i++) send_sample(-16'sh8000, 16'sd0, 16'd30);
    // Sharp turns at both yaw extremes and right at the threshold.
    send_sample(-16'sh8000, -16'sh8000, 16'd30);
    send_sample(-16'sh8000, 16'sh7fff, 16'd30);
    send_sample(-16'sh8000, 16'sd15000, 16'd30);
    send_sample(-16'sh8000, -16'sd15001, 16'd30);
    send_sample(-16'sh8000, -16'sd15001, 16'd30);

    // Zero thresholds: every nonzero jerk or yaw is a candidate, and a candidate is emitted
    // on the second request in a row that carries it.
    set_limits(16'h8000, 16'h0000, 16'h0000, 16'h0000);
    run_random(150);
    // Top of every range: only the most negative yaw can trigger, persistence saturates.
    set_limits(16'hffff, 16'h7fff, 16'hffff, 16'hffff);
    run_random(150);
    for (int p = 0; p < 5; p++) begin
      set_limits(16'($urandom_range(0, 4000)) | 16'($urandom_range(0, 1) << 15),
                 16'($urandom_range(8000, 32767)) | 16'($urandom_range(0, 1) << 15),
                 16'($urandom_range(0, 300)), 16'($urandom_range(0, 2000)));
      run_random(170);
    end

    drain_results();
    if (err_count == 0 && pending == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
